// ===== sv/usb_standard_request_handler_unit_macros.svh =====
// Assertion macros used by the checker module of this block.
`ifndef USB_STANDARD_REQUEST_HANDLER_UNIT_MACROS_SVH
`define USB_STANDARD_REQUEST_HANDLER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define USRH_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("usrh assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define USRH_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("usrh assertion failed");

`endif

// ===== sv/usrh_pkg.sv =====
package usrh_pkg;

	// Result actions.
	typedef enum logic [2:0] {
		ACT_ZLP      = 3'd0,
		ACT_STATUS   = 3'd1,
		ACT_STALL    = 3'd2,
		ACT_BUSY     = 3'd3,
		ACT_DELEGATE = 3'd4
	} action_t;

	// Classes of a delegated control transfer.
	localparam logic [1:0] DK_READ     = 2'd0;
	localparam logic [1:0] DK_WRITE    = 2'd1;
	localparam logic [1:0] DK_DATALESS = 2'd2;

	// Request type field of bmRequestType.
	localparam logic [1:0] RT_STANDARD = 2'd0;

	// Standard request codes.
	localparam logic [7:0] REQ_GET_STATUS     = 8'd0;
	localparam logic [7:0] REQ_CLEAR_FEATURE  = 8'd1;
	localparam logic [7:0] REQ_SET_FEATURE    = 8'd3;
	localparam logic [7:0] REQ_SET_ADDRESS    = 8'd5;
	localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;

	// Recipients.
	localparam logic [4:0] RCP_DEVICE    = 5'd0;
	localparam logic [4:0] RCP_INTERFACE = 5'd1;
	localparam logic [4:0] RCP_ENDPOINT  = 5'd2;

	// Descriptor types that only exist at high speed.
	localparam logic [7:0] DT_QUALIFIER   = 8'd6;
	localparam logic [7:0] DT_OTHER_SPEED = 8'd7;

	// Feature selectors.
	localparam logic [15:0] FS_ENDPOINT_HALT = 16'd0;
	localparam logic [15:0] FS_REMOTE_WAKEUP = 16'd1;

	// Configuration port.
	localparam int APB_AW = 4;
	localparam logic [1:0] REG_ENDPOINT_COUNT = 2'd0;
	localparam logic [1:0] REG_HIGH_SPEED     = 2'd1;
	localparam logic [1:0] REG_SELF_POWERED   = 2'd2;
	localparam logic [1:0] REG_STATUS         = 2'd3;
	localparam logic [4:0] ENDPOINT_COUNT_RST = 5'd16;

	typedef struct packed {
		logic [7:0]  request_type;
		logic [7:0]  request;
		logic [15:0] value;
		logic [15:0] index;
		logic [15:0] length;
		logic        ep0_queue_empty;
	} in_item_t;

	typedef struct packed {
		logic [2:0] action;
		logic [1:0] status_word;
		logic       stall_ep0_after;
		logic       apply_address;
		logic [6:0] device_address;
		logic       restart_valid;
		logic [3:0] restart_endpoint;
		logic [1:0] delegate_kind;
	} out_item_t;

	typedef struct packed {
		logic [4:0] endpoint_count;
		logic       high_speed;
		logic       self_powered;
	} cfg_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic decode;
		logic commit;
	} ctrl_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic out_free;
	} dp_status_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_DECODE = 2'd1,
		ST_EXEC   = 2'd2
	} state_t;

endpackage

// ===== sv/usrh_regs.sv =====
module usrh_regs
	import usrh_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic [1:0]        last_kind,
	output cfg_t              cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.endpoint_count <= ENDPOINT_COUNT_RST;
			cfg_q.high_speed     <= 1'b0;
			cfg_q.self_powered   <= 1'b0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_ENDPOINT_COUNT: cfg_q.endpoint_count <= pwdata[4:0];
				REG_HIGH_SPEED:     cfg_q.high_speed     <= pwdata[0];
				REG_SELF_POWERED:   cfg_q.self_powered   <= pwdata[0];
				REG_STATUS: begin
				end
				default: begin
				end
			endcase
		end
	end

	// The status word is read only and shows the class of the last delegated transfer.
	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_ENDPOINT_COUNT: prdata[4:0] = cfg_q.endpoint_count;
			REG_HIGH_SPEED:     prdata[0]   = cfg_q.high_speed;
			REG_SELF_POWERED:   prdata[0]   = cfg_q.self_powered;
			REG_STATUS:         prdata[1:0] = last_kind;
			default:            prdata      = '0;
		endcase
	end

endmodule

// ===== sv/usrh_ctrl.sv =====
module usrh_ctrl
	import usrh_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_nxt = ST_DECODE;
			ST_DECODE: state_nxt = ST_EXEC;
			ST_EXEC:   if (status.out_free) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_DECODE: cmd.decode = 1'b1;
			ST_EXEC:   cmd.commit = status.out_free;
			default: begin
				cmd      = '0;
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

// ===== sv/usrh_dp.sv =====
module usrh_dp
	import usrh_pkg::*;
#(
	parameter int MAX_ENDPOINTS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ctrl_cmd_t  cmd,
	output dp_status_t status,
	input  in_item_t   in_data,
	input  cfg_t       cfg,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_data,
	output logic [1:0] last_kind
);

	localparam int EPW = (MAX_ENDPOINTS > 1) ? $clog2(MAX_ENDPOINTS) : 1;
	localparam logic [6:0] EP_LIMIT = 7'(MAX_ENDPOINTS);

	typedef enum logic [2:0] {
		OP_GS_DEVICE,
		OP_GS_INTERFACE,
		OP_GS_ENDPOINT,
		OP_FEAT_ENDPOINT,
		OP_FEAT_DEVICE,
		OP_SET_ADDRESS,
		OP_STALL,
		OP_DELEGATE
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       set;
		logic       halt;
		logic [3:0] ep;
		logic [6:0] addr;
		logic [1:0] dkind;
		logic       q_empty;
	} dec_t;

	in_item_t  pkt_q;
	dec_t      dec_q;
	dec_t      dec_nxt;
	logic [MAX_ENDPOINTS-1:0] halt_q;
	logic      rw_q;
	logic [6:0] addr_q;
	logic [1:0] last_kind_q;
	out_item_t out_q;
	logic      out_valid_q;

	logic [4:0] recip;
	logic [6:0] ep7;
	logic       ep_ok;
	logic       standard;

	out_item_t res;
	logic      halt_wr;
	logic      halt_val;
	logic      rw_wr;
	logic      addr_wr;
	logic      kind_wr;

	assign status.out_free = !out_valid_q || !out_stall;
	assign out_valid       = out_valid_q;
	assign out_data        = out_q;
	assign last_kind       = last_kind_q;

	always_ff @(posedge clk) begin
		if (cmd.load) pkt_q <= in_data;
		if (cmd.decode) dec_q <= dec_nxt;
		if (cmd.commit) out_q <= res;
	end

	// Decode the setup packet into an operation class.
	assign recip    = pkt_q.request_type[4:0];
	assign ep7      = pkt_q.index[6:0];
	assign ep_ok    = (ep7 < {2'b00, cfg.endpoint_count}) && (ep7 < EP_LIMIT);
	assign standard = (pkt_q.request_type[6:5] == RT_STANDARD);

	always_comb begin
		dec_nxt         = '0;
		dec_nxt.op      = OP_DELEGATE;
		dec_nxt.set     = (pkt_q.request == REQ_SET_FEATURE);
		dec_nxt.halt    = ep_ok ? halt_q[ep7[EPW-1:0]] : 1'b0;
		dec_nxt.ep      = ep7[3:0];
		dec_nxt.addr    = pkt_q.value[6:0];
		dec_nxt.q_empty = pkt_q.ep0_queue_empty;
		if (pkt_q.request_type[7]) begin
			dec_nxt.dkind = DK_READ;
		end else if (pkt_q.length == 16'd0) begin
			dec_nxt.dkind = DK_DATALESS;
		end else begin
			dec_nxt.dkind = DK_WRITE;
		end
		if (standard) begin
			unique case (pkt_q.request) inside
				REQ_GET_STATUS: begin
					if (recip == RCP_ENDPOINT) begin
						dec_nxt.op = ep_ok ? OP_GS_ENDPOINT : OP_STALL;
					end else if (recip == RCP_DEVICE) begin
						dec_nxt.op = OP_GS_DEVICE;
					end else if (recip == RCP_INTERFACE) begin
						dec_nxt.op = OP_GS_INTERFACE;
					end else begin
						dec_nxt.op = OP_STALL;
					end
				end
				REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
					if (recip == RCP_ENDPOINT && ep_ok && pkt_q.value == FS_ENDPOINT_HALT) begin
						dec_nxt.op = OP_FEAT_ENDPOINT;
					end else if (recip == RCP_DEVICE && pkt_q.value == FS_REMOTE_WAKEUP) begin
						dec_nxt.op = OP_FEAT_DEVICE;
					end else begin
						dec_nxt.op = OP_STALL;
					end
				end
				REQ_SET_ADDRESS: dec_nxt.op = OP_SET_ADDRESS;
				REQ_GET_DESCRIPTOR: begin
					if (!cfg.high_speed && (pkt_q.value[15:8] == DT_QUALIFIER ||
							pkt_q.value[15:8] == DT_OTHER_SPEED)) begin
						dec_nxt.op = OP_STALL;
					end
				end
				default: dec_nxt.op = OP_DELEGATE;
			endcase
		end
	end

	// Build the result and the state updates of the decoded request.
	always_comb begin
		res                = '0;
		res.device_address = addr_q;
		halt_wr            = 1'b0;
		halt_val           = 1'b0;
		rw_wr              = 1'b0;
		addr_wr            = 1'b0;
		kind_wr            = 1'b0;
		unique case (dec_q.op) inside
			OP_GS_DEVICE, OP_GS_INTERFACE, OP_GS_ENDPOINT: begin
				if (!dec_q.q_empty) begin
					res.action = ACT_BUSY;
				end else begin
					res.action = ACT_STATUS;
					if (dec_q.op == OP_GS_DEVICE) begin
						res.status_word = {rw_q, cfg.self_powered};
					end else if (dec_q.op == OP_GS_ENDPOINT) begin
						res.status_word = {1'b0, dec_q.halt};
					end
				end
			end
			OP_FEAT_ENDPOINT: begin
				// A halt request on endpoint zero only stalls after the status stage.
				halt_wr  = !(dec_q.set && dec_q.ep == 4'd0);
				halt_val = dec_q.set;
				if (!dec_q.q_empty) begin
					res.action = ACT_BUSY;
				end else begin
					res.action           = ACT_ZLP;
					res.stall_ep0_after  = dec_q.set && dec_q.ep == 4'd0;
					res.restart_valid    = !dec_q.set;
					res.restart_endpoint = dec_q.set ? 4'd0 : dec_q.ep;
				end
			end
			OP_FEAT_DEVICE: begin
				rw_wr      = 1'b1;
				res.action = dec_q.q_empty ? ACT_ZLP : ACT_BUSY;
			end
			OP_SET_ADDRESS: begin
				addr_wr            = 1'b1;
				res.device_address = dec_q.addr;
				res.action         = dec_q.q_empty ? ACT_ZLP : ACT_BUSY;
				res.apply_address  = dec_q.q_empty;
			end
			OP_STALL: res.action = ACT_STALL;
			OP_DELEGATE: begin
				kind_wr           = 1'b1;
				res.action        = ACT_DELEGATE;
				res.delegate_kind = dec_q.dkind;
			end
			default: res.action = ACT_STALL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halt_q      <= '0;
			rw_q        <= 1'b0;
			addr_q      <= 7'd0;
			last_kind_q <= DK_READ;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				if (halt_wr) halt_q[dec_q.ep[EPW-1:0]] <= halt_val;
				if (rw_wr) rw_q <= dec_q.set;
				if (addr_wr) addr_q <= dec_q.addr;
				if (kind_wr) last_kind_q <= dec_q.dkind;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/usb_standard_request_handler_unit.sv =====
// USB standard request handler.
// The input channel (in_valid, in_stall, in_data) carries one setup packet per
// transaction together with the endpoint zero queue-empty flag. The output channel
// (out_valid, out_stall, out_data) returns exactly one result per packet.
// A packet is registered when accepted, decoded in the next cycle and executed in
// the EXEC state once the output register is free, when the result enters the
// output register. The sequencer handles one packet at a time, so a new packet
// is taken only after the previous one has been executed.
// A result waiting in the output register does not hold off the next packet; only
// when a second result is ready and the first is still stalled does the execute
// step wait, and in_stall stays high until it can finish.
// Reset clears all endpoint halt bits, remote wakeup, the device address and the
// last transfer class; endpoint_count returns to 16, high_speed and self_powered
// to zero. Configuration is written over the APB port at byte addresses 0, 4, 8;
// address 12 reads back the class of the last delegated transfer.
module usb_standard_request_handler_unit
	import usrh_pkg::*;
#(
	parameter int MAX_ENDPOINTS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output out_item_t         out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t       cfg;
	ctrl_cmd_t  cmd;
	dp_status_t dp_status;
	logic [1:0] last_kind;

	usrh_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.last_kind (last_kind),
		.cfg       (cfg)
	);

	usrh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (dp_status),
		.cmd      (cmd)
	);

	usrh_dp #(
		.MAX_ENDPOINTS (MAX_ENDPOINTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (dp_status),
		.in_data   (in_data),
		.cfg       (cfg),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.last_kind (last_kind)
	);

endmodule

// ===== sv/usrh_checker.sv =====
`include "usb_standard_request_handler_unit_macros.svh"

module usrh_checker
	import usrh_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	// The block works on one packet at a time.
	`USRH_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_valid && !in_stall, in_stall)

	// A stalled result holds.
	`USRH_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(out_data))

	// Only a completed clear-halt transaction restarts an endpoint queue.
	`USRH_ASSERT_NOW(a_restart_zlp, clk, arst_n, out_valid && out_data.restart_valid,
		out_data.action == ACT_ZLP && !out_data.stall_ep0_after)

	// A status word is only reported together with a two-byte status stage.
	`USRH_ASSERT_NOW(a_status_only, clk, arst_n,
		out_valid && out_data.action != ACT_STATUS,
		out_data.status_word == 2'd0)

endmodule

bind usb_standard_request_handler_unit usrh_checker u_usrh_checker (.*);

// ===== verif/tb.sv =====
module tb;
	import usrh_pkg::*;

	localparam int MAX_EP = 16;
	localparam int PHASE_ITEMS = 115;

	typedef struct {
		in_item_t  setup;
		bit        typed;
		out_item_t reply;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	in_item_t          in_data = '0;
	logic              out_stall = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	wire               in_stall;
	wire               out_valid;
	out_item_t         out_data;
	wire [31:0]        prdata;
	wire               pready;

	// Shadow copy of the block's state and registers.
	logic       halt_flags [MAX_EP];
	logic       wake_flag = 1'b0;
	logic [6:0] addr_shadow = '0;
	logic [1:0] last_kind = DK_READ;
	logic [4:0] ep_count_cfg = ENDPOINT_COUNT_RST;
	logic       hs_cfg = 1'b0;
	logic       sp_cfg = 1'b0;

	out_item_t setup_replies [$];
	out_item_t want;
	logic      bad;
	int        mismatch_count = 0;
	int        result_count = 0;
	int        zlp_count = 0;
	int        status_count = 0;
	int        stall_count = 0;
	int        busy_count = 0;
	int        delegate_count = 0;
	int        setting_count = 1;
	int        burst_left = 0;
	bit        gaps_on = 1'b1;
	bit        hold_request = 1'b0;
	int        hold_count = 0;

	usb_standard_request_handler_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 500000);
		$display("tb: done, errors");
		$finish;
	end

	function automatic out_item_t predict_reply(in_item_t s);
		out_item_t r;
		logic [4:0] recip;
		logic [6:0] ep;
		logic       ep_ok;
		logic       hand_off;
		logic       set_f;
		r = '0;
		r.action = ACT_DELEGATE;
		recip = s.request_type[4:0];
		ep = s.index[6:0];
		ep_ok = (ep < {2'b00, ep_count_cfg}) && (int'(ep) < MAX_EP);
		hand_off = 1'b1;
		set_f = (s.request == REQ_SET_FEATURE);
		if (s.request_type[6:5] == RT_STANDARD) begin
			hand_off = 1'b0;
			if (s.request == REQ_GET_STATUS) begin
				r.action = ACT_STATUS;
				if (recip == RCP_ENDPOINT) begin
					if (!ep_ok)
						r.action = ACT_STALL;
					else
						r.status_word = {1'b0, halt_flags[ep[3:0]]};
				end else if (recip == RCP_DEVICE) begin
					r.status_word = {wake_flag, sp_cfg};
				end else if (recip != RCP_INTERFACE) begin
					r.action = ACT_STALL;
				end
				if (r.action == ACT_STALL) begin
					r.status_word = '0;
				end else if (!s.ep0_queue_empty) begin
					r.action = ACT_BUSY;
					r.status_word = '0;
				end
			end else if (s.request == REQ_CLEAR_FEATURE || s.request == REQ_SET_FEATURE) begin
				r.action = ACT_ZLP;
				if (recip == RCP_ENDPOINT && ep_ok && s.value == FS_ENDPOINT_HALT) begin
					if (set_f) begin
						// Endpoint zero is never marked halted, only stalled after status.
						if (ep == 7'd0)
							r.stall_ep0_after = 1'b1;
						else
							halt_flags[ep[3:0]] = 1'b1;
					end else begin
						halt_flags[ep[3:0]] = 1'b0;
						r.restart_valid = 1'b1;
						r.restart_endpoint = ep[3:0];
					end
				end else if (recip == RCP_DEVICE && s.value == FS_REMOTE_WAKEUP) begin
					wake_flag = set_f;
				end else begin
					r.action = ACT_STALL;
				end
				if (r.action == ACT_ZLP && !s.ep0_queue_empty)
					r.action = ACT_BUSY;
				if (r.action != ACT_ZLP) begin
					r.stall_ep0_after = 1'b0;
					r.restart_valid = 1'b0;
					r.restart_endpoint = '0;
				end
			end else if (s.request == REQ_SET_ADDRESS) begin
				// The address is taken even when the status stage cannot be queued.
				addr_shadow = s.value[6:0];
				if (s.ep0_queue_empty) begin
					r.action = ACT_ZLP;
					r.apply_address = 1'b1;
				end else begin
					r.action = ACT_BUSY;
				end
			end else if (s.request == REQ_GET_DESCRIPTOR && !hs_cfg &&
					(s.value[15:8] == DT_QUALIFIER || s.value[15:8] == DT_OTHER_SPEED)) begin
				r.action = ACT_STALL;
			end else begin
				hand_off = 1'b1;
			end
		end
		if (hand_off) begin
			r.action = ACT_DELEGATE;
			if (s.request_type[7])
				r.delegate_kind = DK_READ;
			else if (s.length == 16'd0)
				r.delegate_kind = DK_DATALESS;
			else
				r.delegate_kind = DK_WRITE;
			last_kind = r.delegate_kind;
		end
		r.device_address = addr_shadow;
		return r;
	endfunction

	function automatic in_item_t random_setup();
		in_item_t s;
		logic [4:0] recip;
		int pick;
		s.request_type = 8'($urandom);
		s.request = 8'($urandom);
		s.value = 16'($urandom);
		s.index = 16'($urandom);
		s.length = 16'($urandom);
		s.ep0_queue_empty = ($urandom_range(0, 3) != 0);
		pick = $urandom_range(0, 99);
		if (pick < 85) begin
			// Standard request, mostly well-formed, with random content.
			recip = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 2));
			s.request_type = {1'($urandom), RT_STANDARD, recip};
			if ($urandom_range(0, 3) != 0)
				s.index[6:0] = 7'($urandom_range(0, 19));
			case ($urandom_range(0, 5)) inside
				0: s.request = REQ_GET_STATUS;
				1, 2: begin
					s.request = ($urandom_range(0, 1) == 1) ? REQ_SET_FEATURE : REQ_CLEAR_FEATURE;
					if ($urandom_range(0, 9) != 0)
						s.value = ($urandom_range(0, 1) == 1) ? FS_REMOTE_WAKEUP
							: FS_ENDPOINT_HALT;
				end
				3: s.request = REQ_SET_ADDRESS;
				4: begin
					s.request = REQ_GET_DESCRIPTOR;
					s.value[15:8] = 8'($urandom_range(1, 8));
				end
				default: ;
			endcase
		end else if (pick < 95) begin
			s.request_type[6:5] = 2'($urandom_range(1, 3));
		end
		return s;
	endfunction

	task automatic send_setup(in_item_t s, bit typed, out_item_t typed_reply);
		out_item_t r;
		@(negedge clk);
		if (burst_left == 0) begin
			if (gaps_on) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		in_valid <= 1'b1;
		in_data <= s;
		do @(posedge clk); while (in_stall);
		r = predict_reply(s);
		setup_replies.push_back(typed ? typed_reply : r);
		burst_left--;
	endtask

	task automatic settle_replies();
		@(negedge clk);
		in_valid <= 1'b0;
		while (setup_replies.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(logic [1:0] sel, logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (sel)
			REG_ENDPOINT_COUNT: ep_count_cfg = data[4:0];
			REG_HIGH_SPEED: hs_cfg = data[0];
			REG_SELF_POWERED: sp_cfg = data[0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// The class of the last delegated transfer is only visible through the status register.
	task automatic check_last_kind();
		logic [31:0] rd;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {REG_STATUS, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd[1:0] !== last_kind) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("tb: last transfer class expected %0d, read %0d", last_kind, rd[1:0]);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (setup_replies.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("tb: result %h with no setup packet pending", out_data);
			end else begin
				want = setup_replies.pop_front();
				bad = (out_data.action !== want.action) ||
					(out_data.status_word !== want.status_word) ||
					(out_data.stall_ep0_after !== want.stall_ep0_after) ||
					(out_data.apply_address !== want.apply_address) ||
					(out_data.device_address !== want.device_address) ||
					(out_data.restart_valid !== want.restart_valid) ||
					(out_data.restart_endpoint !== want.restart_endpoint) ||
					(out_data.delegate_kind !== want.delegate_kind);
				if (bad) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("tb: #%0d want act=%0d st=%0d s0=%0d ap=%0d adr=%0d rv=%0d rep=%0d dk=%0d",
							result_count, want.action, want.status_word, want.stall_ep0_after,
							want.apply_address, want.device_address, want.restart_valid,
							want.restart_endpoint, want.delegate_kind);
						$display("tb: #%0d got  act=%0d st=%0d s0=%0d ap=%0d adr=%0d rv=%0d rep=%0d dk=%0d",
							result_count, out_data.action, out_data.status_word,
							out_data.stall_ep0_after, out_data.apply_address,
							out_data.device_address, out_data.restart_valid,
							out_data.restart_endpoint, out_data.delegate_kind);
					end
				end
			end
			result_count++;
			case (out_data.action)
				ACT_ZLP: zlp_count++;
				ACT_STATUS: status_count++;
				ACT_STALL: stall_count++;
				ACT_BUSY: busy_count++;
				default: delegate_count++;
			endcase
		end
	end

	// Output side: stretches of no stall, random stall, sparse random stall, a fixed pattern, and on request
	// one long hold so that the block backs up into its input.
	initial begin : receiver
		int mode;
		int span;
		int k;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				hold_count++;
				repeat (300) begin
					@(negedge clk);
					out_stall <= 1'b1;
				end
			end else begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(4, 60);
				for (k = 0; k < span; k++) begin
					@(negedge clk);
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= ($urandom_range(0, 1) == 1);
						2: out_stall <= ((k % 5) < 2);
						default: out_stall <= ($urandom_range(0, 7) == 0);
					endcase
				end
			end
		end
	end

	initial begin : stimulus
		dir_row_t   dir_rows [$];
		int         p;
		int         i;
		logic [4:0] cnt;
		logic       hs;
		logic       sp;
		for (i = 0; i < MAX_EP; i++)
			halt_flags[i] = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, run with the registers at their reset values.
		dir_rows.push_back('{{8'h80, REQ_GET_STATUS, 16'h0000, 16'h0000, 16'h0002, 1'b1}, 1'b1,
			{ACT_STATUS, 2'd0, 1'b0, 1'b0, 7'd0, 1'b0, 4'd0, DK_READ}});
		dir_rows.push_back('{{8'h82, REQ_GET_STATUS, 16'h0000, 16'h0081, 16'h0002, 1'b1}, 1'b1,
			{ACT_STATUS, 2'd0, 1'b0, 1'b0, 7'd0, 1'b0, 4'd0, DK_READ}});
		dir_rows.push_back('{{8'h02, REQ_SET_FEATURE, 16'h0000, 16'h0085, 16'h0000, 1'b1}, 1'b0, '0});
		dir_rows.push_back('{{8'h82, REQ_GET_STATUS, 16'h0000, 16'h0005, 16'h0002, 1'b1}, 1'b0, '0});
		dir_rows.push_back('{{8'h02, REQ_CLEAR_FEATURE, 16'h0000, 16'h0005, 16'h0000, 1'b1}, 1'b0, '0});
		dir_rows.push_back('{{8'h02, REQ_SET_FEATURE, 16'h0000, 16'h0080, 16'h0000, 1'b1}, 1'b0, '0});
		dir_rows.push_back('{{8'h00, REQ_SET_FEATURE, 16'h0001, 16'h0000, 16'h0000, 1'b1}, 1'b0, '0});
		dir_rows.push_back('{{8'h80, REQ_GET_STATUS, 16'h0000, 16'h0000, 16'h0002, 1'b1}, 1'b0, '0});
		dir_rows.push_back('{{8'h00, REQ_CLEAR_FEATURE, 16'h0001, 16'h0000, 16'h0000, 1'b0}, 1'b0, '0});
		dir_rows.push_back('{{8'h00, REQ_SET_ADDRESS, 16'hFFFF, 16'h0000, 16'h0000, 1'b1}, 1'b0, '0});
		dir_rows.push_back('{{8'h00, REQ_SET_ADDRESS, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0}, 1'b0, '0});
		dir_rows.push_back('{{8'h82, REQ_GET_STATUS, 16'h0000, 16'h00FF, 16'h0002, 1'b1}, 1'b1,
			{ACT_STALL, 2'd0, 1'b0, 1'b0, 7'd0, 1'b0, 4'd0, DK_READ}});
		dir_rows.push_back('{{8'h81, REQ_GET_STATUS, 16'h0000, 16'h0000, 16'h0002, 1'b1}, 1'b0, '0});
		dir_rows.push_back('{{8'h9F, REQ_GET_STATUS, 16'h0000, 16'h0000, 16'h0002, 1'b1}, 1'b1,
			{ACT_STALL, 2'd0, 1'b0, 1'b0, 7'd0, 1'b0, 4'd0, DK_READ}});
		dir_rows.push_back('{{8'h01, REQ_SET_FEATURE, 16'h0000, 16'h0000, 16'h0000, 1'b1}, 1'b0, '0});
		dir_rows.push_back('{{8'h02, REQ_SET_FEATURE, 16'hFFFF, 16'h0001, 16'h0000, 1'b1}, 1'b0, '0});
		dir_rows.push_back('{{8'h02, REQ_CLEAR_FEATURE, 16'h0001, 16'h0001, 16'h0000, 1'b1}, 1'b0, '0});
		dir_rows.push_back('{{8'h80, REQ_GET_DESCRIPTOR, 16'h0600, 16'h0000, 16'h000A, 1'b1}, 1'b1,
			{ACT_STALL, 2'd0, 1'b0, 1'b0, 7'd0, 1'b0, 4'd0, DK_READ}});
		dir_rows.push_back('{{8'h80, REQ_GET_DESCRIPTOR, 16'h07FF, 16'h0000, 16'hFFFF, 1'b1}, 1'b0, '0});
		dir_rows.push_back('{{8'h80, REQ_GET_DESCRIPTOR, 16'h0100, 16'h0000, 16'h0012, 1'b1}, 1'b0, '0});
		dir_rows.push_back('{{8'h21, 8'h09, 16'h0200, 16'h0000, 16'h0008, 1'b1}, 1'b0, '0});
		dir_rows.push_back('{{8'h40, 8'h01, 16'h0000, 16'h0000, 16'h0000, 1'b1}, 1'b0, '0});
		dir_rows.push_back('{{8'hE0, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0}, 1'b1,
			{ACT_DELEGATE, 2'd0, 1'b0, 1'b0, 7'd0, 1'b0, 4'd0, DK_READ}});
		dir_rows.push_back('{{8'h00, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b0, '0});
		dir_rows.push_back('{{8'h82, REQ_GET_STATUS, 16'h0000, 16'h0003, 16'h0002, 1'b0}, 1'b0, '0});
		foreach (dir_rows[i])
			send_setup(dir_rows[i].setup, dir_rows[i].typed, dir_rows[i].reply);
		settle_replies();
		check_last_kind();

		// Random part, one register setting per phase.
		for (p = 0; p < 6; p++) begin
			case (p)
				0: begin cnt = 5'd1; hs = 1'b1; sp = 1'b1; end
				1: begin cnt = 5'd16; hs = 1'b0; sp = 1'b0; end
				2: begin cnt = 5'd16; hs = 1'b1; sp = 1'b1; end
				3: begin cnt = 5'd5; hs = 1'b0; sp = 1'b1; end
				default: begin
					cnt = 5'($urandom_range(1, 16));
					hs = 1'($urandom);
					sp = 1'($urandom);
				end
			endcase
			apb_write(REG_ENDPOINT_COUNT, ($urandom & 32'hFFFF_FFE0) | cnt);
			apb_write(REG_HIGH_SPEED, ($urandom & 32'hFFFF_FFFE) | hs);
			apb_write(REG_SELF_POWERED, ($urandom & 32'hFFFF_FFFE) | sp);
			setting_count++;
			gaps_on = (p != 3);
			if (p == 2)
				hold_request = 1'b1;
			for (i = 0; i < PHASE_ITEMS; i++)
				send_setup(random_setup(), 1'b0, '0);
			settle_replies();
			check_last_kind();
		end
		repeat (8) @(posedge clk);

		$display("tb: %0d setup packets checked under %0d register settings, %0d long hold(s)",
			result_count, setting_count, hold_count);
		$display("tb: zero-length %0d, status %0d, stall %0d, busy %0d, delegated %0d",
			zlp_count, status_count, stall_count, busy_count, delegate_count);
		if (mismatch_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
